// ----- sv/jet_pkg.sv -----
// Shared widths, register indexes, reset values and types for the Julia escape-time block.
package jet_pkg;

   localparam int FRAC_BITS_DEFAULT = 28;

   localparam int Z_W        = 32;  // start point and iterate components
   localparam int K_W        = 31;  // Julia constant components
   localparam int CNT_W      = 16;  // iteration count and limit
   localparam int PROD_W     = 64;  // full product of two iterate components
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_K_REAL     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_K_IMAG     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 2'd2;

   localparam logic signed [K_W-1:0] K_REAL_RESET     = -31'sd107374182;  // -0.4 at Q3.28
   localparam logic signed [K_W-1:0] K_IMAG_RESET     = 31'sd161061274;   // 0.6 at Q3.28
   localparam logic [CNT_W-1:0]      ITER_LIMIT_RESET = 16'd100;

   // Configuration as seen by the iteration datapath; k is already clamped to +/-2.0.
   typedef struct packed {
      logic [K_W-1:0]   k_real;
      logic [K_W-1:0]   k_imag;
      logic [CNT_W-1:0] iter_limit;
   } cfg_type;

endpackage

// ----- sv/jet_csr.sv -----
// Configuration registers: Julia constant (clamped on write) and iteration limit.
module jet_csr #(
   parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [jet_pkg::CSR_IDX_W-1:0]    wr_index,
   input  logic [jet_pkg::CSR_DATA_W-1:0]   wr_data,
   output jet_pkg::cfg_type                 cfg
);

   localparam logic signed [63:0] K_MAX = 64'sd2 <<< FRAC_BITS;
   localparam logic signed [63:0] K_MIN = -K_MAX;

   // Saturate to [-2.0, +2.0]; the result always fits the register width.
   function automatic logic [jet_pkg::K_W-1:0] clamp_k(input logic [jet_pkg::K_W-1:0] raw);
      logic signed [63:0] v;
      logic signed [63:0] c;
      begin
         v = {{(64 - jet_pkg::K_W){raw[jet_pkg::K_W-1]}}, raw};
         if (v > K_MAX) begin
            c = K_MAX;
         end else if (v < K_MIN) begin
            c = K_MIN;
         end else begin
            c = v;
         end
         clamp_k = c[jet_pkg::K_W-1:0];
      end
   endfunction

   localparam logic [jet_pkg::K_W-1:0] K_REAL_RST = clamp_k(jet_pkg::K_REAL_RESET);
   localparam logic [jet_pkg::K_W-1:0] K_IMAG_RST = clamp_k(jet_pkg::K_IMAG_RESET);

   logic [jet_pkg::K_W-1:0]   k_real_ff, k_real_in;
   logic [jet_pkg::K_W-1:0]   k_imag_ff, k_imag_in;
   logic [jet_pkg::CNT_W-1:0] limit_ff,  limit_in;

   always_comb begin
      k_real_in = k_real_ff;
      k_imag_in = k_imag_ff;
      limit_in  = limit_ff;
      if (wr_en) begin
         case (wr_index)
            jet_pkg::CSR_K_REAL:     k_real_in = clamp_k(wr_data[jet_pkg::K_W-1:0]);
            jet_pkg::CSR_K_IMAG:     k_imag_in = clamp_k(wr_data[jet_pkg::K_W-1:0]);
            jet_pkg::CSR_ITER_LIMIT: limit_in  = wr_data[jet_pkg::CNT_W-1:0];
            default: begin
               // drop writes to unknown indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_real_ff <= K_REAL_RST;
         k_imag_ff <= K_IMAG_RST;
         limit_ff  <= jet_pkg::ITER_LIMIT_RESET;
      end else begin
         k_real_ff <= k_real_in;
         k_imag_ff <= k_imag_in;
         limit_ff  <= limit_in;
      end
   end

   assign cfg.k_real     = k_real_ff;
   assign cfg.k_imag     = k_imag_ff;
   assign cfg.iter_limit = limit_ff;

endmodule

// ----- sv/jet_mul.sv -----
// Shared signed 32x32 multiplier with a registered full-width product.
module jet_mul (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [jet_pkg::Z_W-1:0]    op_a,
   input  logic signed [jet_pkg::Z_W-1:0]    op_b,
   output logic signed [jet_pkg::PROD_W-1:0] product
);

   logic signed [jet_pkg::PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= op_a * op_b;
      end
   end

   assign product = product_ff;

endmodule

// ----- sv/julia_escape_time.sv -----
// Top level of the Julia escape-time block: handshakes, sequencer and iteration datapath.
//
// Each item is a start point z0 (signed fixed point, FRAC_BITS fraction bits, Q4.28 by
// default). The block repeats z = z*z + k and returns the number of iterations done while
// |z|^2 <= 4.0 and the count is below the iteration limit. k comes from the configuration
// registers and is clamped to +/-2.0 when written. One item is worked on at a time: all
// three products of an iteration (zr*zr, zi*zi, zr*zi) go through a single 32x32
// multiplier, so each iteration takes three multiply steps plus an update step, and the
// test that ends the loop costs one more such round. The next item is taken in the cycle
// after the result is taken. The configuration port is always ready; write it only while
// no item is in flight. Register indexes: 0 k_real, 1 k_imag, 2 iteration_limit; writes
// to index 3 are dropped.
module julia_escape_time #(
   parameter int FRAC_BITS = jet_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [jet_pkg::Z_W-1:0]   req_start_real,
   input  logic signed [jet_pkg::Z_W-1:0]   req_start_imag,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [jet_pkg::CNT_W-1:0]        rsp_escape_count,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [jet_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jet_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int PW = jet_pkg::PROD_W;
   localparam int ZW = jet_pkg::Z_W;
   localparam int KW = jet_pkg::K_W;

   // Escape radius 4.0 at the scale of the raw squares; beyond 63 bits every point stays in.
   localparam bit                 ALWAYS_IN = (2 * FRAC_BITS + 2) > 63;
   localparam logic [PW-1:0]      ESC_LIM   = ALWAYS_IN ? '1 : (64'd1 << (2 * FRAC_BITS + 2));
   localparam logic signed [PW-1:0] Z_MAX   = (64'sd1 <<< (ZW - 1)) - 64'sd1;
   localparam logic signed [PW-1:0] Z_MIN   = -(64'sd1 <<< (ZW - 1));

   // Sequencer codes
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MUL_RR = 3'd1;  // issue zr*zr
   localparam logic [2:0] ST_MUL_II = 3'd2;  // issue zi*zi, capture zr^2
   localparam logic [2:0] ST_MUL_RI = 3'd3;  // issue zr*zi, form |z|^2 test and difference
   localparam logic [2:0] ST_STEP   = 3'd4;  // test, then update z or finish
   localparam logic [2:0] ST_DONE   = 3'd5;  // hold the result

   function automatic logic [ZW-1:0] sat_z(input logic signed [PW-1:0] v);
      begin
         if (v > Z_MAX) begin
            sat_z = Z_MAX[ZW-1:0];
         end else if (v < Z_MIN) begin
            sat_z = Z_MIN[ZW-1:0];
         end else begin
            sat_z = v[ZW-1:0];
         end
      end
   endfunction

   jet_pkg::cfg_type cfg;

   logic [2:0]                 state_ff, state_in;
   logic signed [ZW-1:0]       zr_ff, zr_in;
   logic signed [ZW-1:0]       zi_ff, zi_in;
   logic [jet_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [PW-1:0]              sq_r_ff, sq_r_in;
   logic signed [PW-1:0]       diff_ff, diff_in;
   logic                       inside_ff, inside_in;

   logic                       mul_en;
   logic signed [ZW-1:0]       mul_a, mul_b;
   logic signed [PW-1:0]       product;
   logic [PW-1:0]              mag_sum;
   logic signed [PW-1:0]       k_real_ext, k_imag_ext;
   logic signed [PW-1:0]       next_real, next_imag;
   logic                       req_acc, rsp_acc, keep_going;

   assign csr_ready = 1'b1;

   jet_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Operand selection for the shared multiplier
   always_comb begin
      mul_en = state_ff inside {ST_MUL_RR, ST_MUL_II, ST_MUL_RI};
      case (state_ff)
         ST_MUL_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_MUL_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   jet_mul u_mul (
      .clock   (clock),
      .en      (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = (state_ff == ST_DONE);
   assign rsp_escape_count = count_ff;
   assign req_acc          = req_valid && req_ready;
   assign rsp_acc          = rsp_valid && rsp_ready;

   // In ST_MUL_RI the multiplier output holds zi^2; in ST_STEP it holds zr*zi.
   assign mag_sum    = sq_r_ff + product;
   assign k_real_ext = {{(PW - KW){cfg.k_real[KW-1]}}, cfg.k_real};
   assign k_imag_ext = {{(PW - KW){cfg.k_imag[KW-1]}}, cfg.k_imag};
   assign next_real  = (diff_ff >>> FRAC_BITS) + k_real_ext;
   assign next_imag  = (product >>> (FRAC_BITS - 1)) + k_imag_ext;
   assign keep_going = inside_ff && (count_ff != cfg.iter_limit);

   always_comb begin
      state_in  = state_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      count_in  = count_ff;
      sq_r_in   = sq_r_ff;
      diff_in   = diff_ff;
      inside_in = inside_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               zr_in    = req_start_real;
               zi_in    = req_start_imag;
               count_in = '0;
               state_in = ST_MUL_RR;
            end
         end
         ST_MUL_RR: begin
            state_in = ST_MUL_II;
         end
         ST_MUL_II: begin
            sq_r_in  = product;
            state_in = ST_MUL_RI;
         end
         ST_MUL_RI: begin
            inside_in = ALWAYS_IN || (mag_sum <= ESC_LIM);
            diff_in   = $signed(sq_r_ff) - product;
            state_in  = ST_STEP;
         end
         ST_STEP: begin
            if (keep_going) begin
               zr_in    = sat_z(next_real);
               zi_in    = sat_z(next_imag);
               count_in = count_ff + 1'b1;
               state_in = ST_MUL_RR;
            end else begin
               // hold the count as the result
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_acc) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      count_ff  <= count_in;
      sq_r_ff   <= sq_r_in;
      diff_ff   <= diff_in;
      inside_ff <= inside_in;
   end

   // The count never passes the limit it is checked against.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_escape_count <= cfg.iter_limit))
      else $error("escape count above iteration limit");

   // An accepted item starts a fresh count with the first multiply.
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff == ST_MUL_RR) && (count_ff == '0))
      else $error("item did not start a fresh iteration");

   // A passing test advances the count by exactly one and loops back.
   a_step_advance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STEP) && keep_going
      |=> (count_ff == $past(count_ff) + 1'b1) && (state_ff == ST_MUL_RR))
      else $error("iteration step did not advance count");

   // A result waiting to be taken holds its value.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_escape_count))
      else $error("result changed before it was taken");

   // Never take a new item while a result is outstanding.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while result pending");

endmodule

// ----- sim/julia_escape_checker.sv -----
// Checker for the Julia escape-time block: watches all three channels, predicts and compares counts.
module julia_escape_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [jet_pkg::Z_W-1:0]        req_start_real,
   input  logic signed [jet_pkg::Z_W-1:0]        req_start_imag,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [jet_pkg::CNT_W-1:0]             rsp_escape_count,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [jet_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [jet_pkg::CSR_DATA_W-1:0]        csr_data,
   output int                                    failures,
   output int                                    pending
);

   localparam int FRAC = jet_pkg::FRAC_BITS_DEFAULT;
   localparam longint TWO_Q = longint'(2) << FRAC;
   localparam longint Z_MIN = -(longint'(1) << (jet_pkg::Z_W - 1));
   localparam longint Z_MAX = (longint'(1) << (jet_pkg::Z_W - 1)) - 1;
   // |z|^2 = 4.0 at the scale of the raw squares
   localparam longint unsigned ESCAPE_BOUND = 64'd1 << (2 * FRAC + 2);

   logic signed [jet_pkg::K_W-1:0] k_real_q;
   logic signed [jet_pkg::K_W-1:0] k_imag_q;
   logic [jet_pkg::CNT_W-1:0]      limit_q;
   logic [jet_pkg::CNT_W-1:0]      expected_counts [$];
   logic [jet_pkg::CNT_W-1:0]      want_count;

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [jet_pkg::CNT_W-1:0] escape_count_of(
      input logic signed [jet_pkg::Z_W-1:0] sr,
      input logic signed [jet_pkg::Z_W-1:0] si
   );
      longint kr, ki, zr, zi, sq_r, sq_i, nr, ni;
      logic [jet_pkg::CNT_W-1:0] count;
      bit running;
      kr = clamp(longint'(k_real_q), -TWO_Q, TWO_Q);
      ki = clamp(longint'(k_imag_q), -TWO_Q, TWO_Q);
      zr = longint'(sr);
      zi = longint'(si);
      count = '0;
      running = 1'b1;
      while (running && count < limit_q) begin
         sq_r = zr * zr;
         sq_i = zi * zi;
         if ($unsigned(sq_r) + $unsigned(sq_i) > ESCAPE_BOUND) begin
            running = 1'b0;
         end else begin
            // arithmetic shifts floor towards minus infinity
            nr = clamp(((sq_r - sq_i) >>> FRAC) + kr, Z_MIN, Z_MAX);
            ni = clamp(((zr * zi) >>> (FRAC - 1)) + ki, Z_MIN, Z_MAX);
            zr = nr;
            zi = ni;
            count++;
         end
      end
      return count;
   endfunction

   task automatic report_mismatch(input string note);
      failures++;
      $display("[%0t] mismatch: %s", $time, note);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         k_real_q = jet_pkg::K_REAL_RESET;
         k_imag_q = jet_pkg::K_IMAG_RESET;
         limit_q  = jet_pkg::ITER_LIMIT_RESET;
         expected_counts.delete();
         pending  = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               jet_pkg::CSR_K_REAL:     k_real_q = csr_data[jet_pkg::K_W-1:0];
               jet_pkg::CSR_K_IMAG:     k_imag_q = csr_data[jet_pkg::K_W-1:0];
               jet_pkg::CSR_ITER_LIMIT: limit_q  = csr_data[jet_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_counts.push_back(escape_count_of(req_start_real, req_start_imag));
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("escape_count %0d with no item outstanding",
                                         rsp_escape_count));
            end else begin
               want_count = expected_counts.pop_front();
               if (rsp_escape_count !== want_count)
                  report_mismatch($sformatf("escape_count expected %0d, got %0d",
                                            want_count, rsp_escape_count));
            end
         end
         pending = expected_counts.size();
      end
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the Julia escape-time block: clock, reset, stimulus, receiver and verdict.
module tb_top;

   // index with no register behind it; writes there must be dropped
   localparam logic [jet_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int TOTAL_ITEMS  = 1250;
   localparam int CALM_ITEMS   = 150;  // final stretch with no idling on either side
   localparam int HOLD_AFTER   = 300;  // results taken before the long receiver hold-off
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;

   localparam logic signed [jet_pkg::Z_W-1:0] Q_TWO  = 32'sh2000_0000;  // 2.0
   localparam logic signed [jet_pkg::Z_W-1:0] Q_HALF = 32'sh0800_0000;  // 0.5
   localparam logic signed [jet_pkg::Z_W-1:0] Q_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [jet_pkg::Z_W-1:0] Q_MIN  = 32'sh8000_0000;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [jet_pkg::Z_W-1:0]       req_start_real;
   logic signed [jet_pkg::Z_W-1:0]       req_start_imag;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic [jet_pkg::CNT_W-1:0]            rsp_escape_count;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [jet_pkg::CSR_IDX_W-1:0]        csr_index;
   logic [jet_pkg::CSR_DATA_W-1:0]       csr_data;

   int failures;
   int pending;
   int items_sent = 0;
   bit calm = 1'b0;

   julia_escape_time dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_real   (req_start_real),
      .req_start_imag   (req_start_imag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   julia_escape_checker checker_inst (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_real   (req_start_real),
      .req_start_imag   (req_start_imag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_escape_count (rsp_escape_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .failures         (failures),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: the slowest correct run (every item at its limit, the item that runs
   // the full 16-bit count, every stall and gap) stays well under a fifth of this.
   initial begin
      #100_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Offer one start point and hold it until the block takes it. Now and then open a
   // gap first, with noise on the payload while valid is low.
   task automatic send_point(input logic signed [jet_pkg::Z_W-1:0] sr,
                             input logic signed [jet_pkg::Z_W-1:0] si);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid      = 1'b0;
         req_start_real = $urandom;
         req_start_imag = $urandom;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      = 1'b1;
      req_start_real = sr;
      req_start_imag = si;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Drop valid and pause until every outstanding item has come back. Each item gives
   // exactly one result, so the block is idle once nothing is pending.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [jet_pkg::CSR_IDX_W-1:0] idx,
                            input logic [jet_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Julia constant word: mostly within +/-2.0, sometimes anywhere in 31 bits so the
   // clamp is exercised, sometimes the 31-bit extremes. Bit 31 is ignored by the block.
   function automatic logic [jet_pkg::CSR_DATA_W-1:0] random_k_word();
      logic [jet_pkg::K_W-1:0] k;
      int v;
      v = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      case ($urandom_range(0, 9))
         0:       k = 31'($urandom);
         1:       k = $urandom_range(0, 1) ? 31'h3FFF_FFFF : 31'h4000_0000;
         default: k = v[jet_pkg::K_W-1:0];
      endcase
      return {1'($urandom), k};
   endfunction

   // Limits stay small so the run stays short; zero and the reset range turn up too.
   function automatic logic [jet_pkg::CSR_DATA_W-1:0] random_limit_word();
      logic [jet_pkg::CNT_W-1:0] lim;
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         lim = '0;
      else if (r < 86)
         lim = 16'($urandom_range(1, 24));
      else
         lim = 16'($urandom_range(25, 100));
      return {16'($urandom), lim};
   endfunction

   // Mostly points in the +/-2.0 square, where orbits live long; the rest full-range
   // noise, the values at the escape radius and one step past it, and the field extremes.
   function automatic logic signed [jet_pkg::Z_W-1:0] random_coord();
      logic signed [jet_pkg::Z_W-1:0] c;
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) begin
         c = int'($urandom_range(0, 1 << 30)) - (1 << 29);
      end else if (r < 17) begin
         c = $urandom;
      end else begin
         case ($urandom_range(0, 5))
            0:       c = Q_TWO;
            1:       c = -Q_TWO;
            2:       c = Q_TWO + 1;
            3:       c = -Q_TWO - 1;
            4:       c = Q_MAX;
            default: c = Q_MIN;
         endcase
      end
      return c;
   endfunction

   // Receiver: short random stalls, one long hold-off while the sender keeps offering
   // so the block fills and stalls its input, and no stalls in the calm stretch.
   initial begin : receiver
      int taken;
      int stall_left;
      bit held;
      taken      = 0;
      stall_left = 0;
      held       = 1'b0;
      rsp_ready  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held && taken >= HOLD_AFTER) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held = 1'b1;
         end
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_ready = 1'b1;
         end
         @(posedge clock);
         if (rsp_valid && rsp_ready) taken++;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase_len;
      int n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_start_real = '0;
      req_start_imag = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset constant -0.4+0.6i, limit 100: field extremes, the escape radius hit
      // exactly and by one step past it, and negative products that floor.
      send_point(0, 0);
      send_point(Q_MAX, Q_MAX);
      send_point(Q_MIN, Q_MIN);
      send_point(Q_MAX, Q_MIN);
      send_point(Q_MIN, Q_MAX);
      send_point(Q_TWO, 0);
      send_point(0, Q_TWO);
      send_point(-Q_TWO, 0);
      send_point(0, -Q_TWO);
      send_point(Q_TWO + 1, 0);
      send_point(0, -Q_TWO - 1);
      send_point(-1, -1);
      send_point(-1, 1);
      send_point(Q_HALF, -Q_HALF);

      // Zero limit, with k at the 31-bit extremes; the unmapped index must change nothing.
      settle();
      write_reg(CSR_UNMAPPED, 32'hFFFF_FFFF);
      write_reg(jet_pkg::CSR_K_REAL, 32'h3FFF_FFFF);
      write_reg(jet_pkg::CSR_K_IMAG, 32'hC000_0000);
      write_reg(jet_pkg::CSR_ITER_LIMIT, 32'hFFFF_0000);
      send_point(0, 0);
      send_point(Q_MAX, Q_MIN);
      send_point(Q_TWO, -Q_TWO);

      // k_real far above 2.0 must clamp to exactly 2.0: from zero the orbit sits on
      // the escape radius once before leaving, which an unclamped k would not do.
      settle();
      write_reg(jet_pkg::CSR_K_IMAG, 32'h0000_0000);
      write_reg(jet_pkg::CSR_ITER_LIMIT, 32'h0000_0003);
      send_point(0, 0);
      send_point(-1, -1);

      // Clamp from the other side: k_real far below -2.0, k_imag at its top.
      settle();
      write_reg(jet_pkg::CSR_K_REAL, 32'h4000_0000);
      write_reg(jet_pkg::CSR_K_IMAG, 32'hBFFF_FFFF);
      write_reg(jet_pkg::CSR_ITER_LIMIT, 32'h0000_0005);
      send_point(0, 0);
      send_point(Q_TWO, 0);

      // Full 16-bit limit with k = 0: the origin never escapes and runs to the top
      // count; the point just past the radius leaves at once, the one on it after one step.
      settle();
      write_reg(jet_pkg::CSR_K_REAL, 32'h0000_0000);
      write_reg(jet_pkg::CSR_K_IMAG, 32'h0000_0000);
      write_reg(jet_pkg::CSR_ITER_LIMIT, 32'h0000_FFFF);
      send_point(0, 0);
      send_point(Q_TWO + 1, 0);
      send_point(Q_TWO, 0);

      // Random phases: new settings between phases, always a fresh (small) limit.
      while (items_sent < TOTAL_ITEMS) begin
         settle();
         if ($urandom_range(0, 5) == 0)
            write_reg(CSR_UNMAPPED, $urandom);
         if ($urandom_range(0, 3) != 0)
            write_reg(jet_pkg::CSR_K_REAL, random_k_word());
         if ($urandom_range(0, 3) != 0)
            write_reg(jet_pkg::CSR_K_IMAG, random_k_word());
         write_reg(jet_pkg::CSR_ITER_LIMIT, random_limit_word());
         phase_len = $urandom_range(40, 120);
         for (n = 0; n < phase_len && items_sent < TOTAL_ITEMS; n++) begin
            calm = (items_sent >= TOTAL_ITEMS - CALM_ITEMS);
            send_point(random_coord(), random_coord());
         end
      end

      // Drain, then give anything stray time to show up before the verdict.
      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
